@@ design/wsd_pkg.sv @@
// Shared constants, codes and types for the work stealing deque.
package wsd_pkg;

	// Default sizes
	localparam int DEPTH_DEF    = 256;
	localparam int JOB_BITS_DEF = 32;

	// Operation codes on the kind field
	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_POP   = 2'd1;
	localparam logic [1:0] KIND_STEAL = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_QUEUED    = 2'd0;
	localparam logic [1:0] STAT_INLINE    = 2'd1;
	localparam logic [1:0] STAT_DELIVERED = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	// Sequencer states
	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	// Decision of the pointer unit for the item on the input
	typedef struct packed {
		logic       wr_en;   // push that fits: store the job
		logic       rd_en;   // pop or steal on a non-empty queue: fetch the job
		logic [1:0] status;  // status of an item answered without a read
	} ctl_t;

endpackage

@@ design/wsd_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface wsd_req_if #(
	parameter int JOB_BITS = wsd_pkg::JOB_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [1:0]          kind;
	logic [JOB_BITS-1:0] job_word;

	modport source (output valid, output kind, output job_word, input ready);
	modport sink   (input valid, input kind, input job_word, output ready);
endinterface

interface wsd_rsp_if #(
	parameter int JOB_BITS = wsd_pkg::JOB_BITS_DEF,
	parameter int OCC_BITS = 9
) ();
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [JOB_BITS-1:0] job_out;
	logic [OCC_BITS-1:0] occupancy;

	modport source (output valid, output status, output job_out, output occupancy,
		input ready);
	modport sink   (input valid, input status, input job_out, input occupancy,
		output ready);
endinterface

@@ design/wsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wsd_ram #(
	parameter int WIDTH = wsd_pkg::JOB_BITS_DEF,
	parameter int DEPTH = wsd_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ design/wsd_ptrs.sv @@
// Top and bottom pointers, occupancy and per-item decision for the deque.
module wsd_ptrs #(
	parameter int DEPTH = wsd_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 kind,
	output wsd_pkg::ctl_t              ctl,
	output logic [$clog2(DEPTH)-1:0]   slot,
	output logic [$clog2(DEPTH+1)-1:0] occ_next
);
	import wsd_pkg::*;

	localparam int PW = $clog2(2 * DEPTH);
	localparam int SW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [PW:0]   PMOD  = (PW + 1)'(2 * DEPTH);
	localparam logic [PW-1:0] PLAST = PW'(2 * DEPTH - 1);
	localparam logic [PW-1:0] PHALF = PW'(DEPTH);
	localparam logic [OW-1:0] OFULL = OW'(DEPTH);

	logic [PW-1:0] top_q, bot_q;
	logic [PW-1:0] top_inc, bot_inc, bot_dec, rd_ptr;
	logic [PW:0]   diff;
	logic [OW-1:0] occ;
	logic          full, empty;

	// Pointer arithmetic modulo twice the depth
	assign top_inc = (top_q == PLAST) ? '0 : top_q + PW'(1);
	assign bot_inc = (bot_q == PLAST) ? '0 : bot_q + PW'(1);
	assign bot_dec = (bot_q == '0) ? PLAST : bot_q - PW'(1);

	// Current occupancy
	always_comb begin
		diff = {1'b0, bot_q} - {1'b0, top_q};
		if (bot_q < top_q) begin
			diff = diff + PMOD;
		end
	end
	assign occ   = diff[OW-1:0];
	assign full  = (occ == OFULL);
	assign empty = (occ == '0);

	// Ring slot: write at bottom, pop reads below bottom, steal reads at top
	always_comb begin
		case (kind)
			KIND_POP: rd_ptr = bot_dec;
			KIND_STEAL: rd_ptr = top_q;
			default: rd_ptr = bot_q;
		endcase
	end
	assign slot = (rd_ptr >= PHALF) ? SW'(rd_ptr - PHALF) : SW'(rd_ptr);

	// Decision and occupancy after the item
	always_comb begin
		ctl.wr_en  = 1'b0;
		ctl.rd_en  = 1'b0;
		ctl.status = STAT_EMPTY;
		occ_next   = occ;
		case (kind)
			KIND_PUSH: begin
				if (full) begin
					ctl.status = STAT_INLINE;
				end else begin
					ctl.wr_en  = 1'b1;
					ctl.status = STAT_QUEUED;
					occ_next   = occ + OW'(1);
				end
			end
			KIND_POP, KIND_STEAL: begin
				if (!empty) begin
					ctl.rd_en  = 1'b1;
					ctl.status = STAT_DELIVERED;
					occ_next   = occ - OW'(1);
				end
			end
			default: ;
		endcase
	end

	// Pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			bot_q <= '0;
		end else if (accept) begin
			if (ctl.wr_en) begin
				bot_q <= bot_inc;
			end else if (ctl.rd_en && kind == KIND_POP) begin
				bot_q <= bot_dec;
			end else if (ctl.rd_en && kind == KIND_STEAL) begin
				top_q <= top_inc;
			end
		end
	end
endmodule

@@ design/work_stealing_deque.sv @@
// Work stealing deque top level: pointer unit, job ring memory and response register.
// A bounded double-ended job queue. A push stores its job at the bottom, or
// when the queue already holds DEPTH jobs hands it straight back with status
// "run inline"; a pop returns the newest job from the bottom, a steal the
// oldest from the top, and either reports empty when nothing is queued. Every
// item gives exactly one response carrying the occupancy after it. A push, or
// any item answered without a job from the ring, goes straight into the
// response register, so such items can follow each other every cycle
// while responses are taken. A pop or steal that delivers a job goes through the
// synchronous ring read and the read state before its response is registered;
// the request channel holds ready low in the read state. Only the pointers, the
// sequencer state and the response valid are reset; the ring needs no clearing.
module work_stealing_deque #(
	parameter int DEPTH    = wsd_pkg::DEPTH_DEF,
	parameter int JOB_BITS = wsd_pkg::JOB_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	wsd_req_if.sink  req,
	wsd_rsp_if.source rsp
);
	import wsd_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);

	state_t              state_q, state_d;
	ctl_t                ctl;
	logic [SW-1:0]       slot;
	logic [OW-1:0]       occ_next;
	logic [OW-1:0]       occ_s1;
	logic [JOB_BITS-1:0] rd_data;
	logic                accept;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [JOB_BITS-1:0] job_q;
	logic [OW-1:0]       occ_q;

	assign accept = req.valid && req.ready;

	// Pointer unit
	wsd_ptrs #(
		.DEPTH(DEPTH)
	) u_ptrs (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (req.kind),
		.ctl      (ctl),
		.slot     (slot),
		.occ_next (occ_next)
	);

	// Job ring
	wsd_ram #(
		.WIDTH(JOB_BITS),
		.DEPTH(DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (accept && ctl.wr_en),
		.waddr (slot),
		.wdata (req.job_word),
		.re    (accept && ctl.rd_en),
		.raddr (slot),
		.rdata (rd_data)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && ctl.rd_en) begin
					state_d = S_READ;
				end
			end
			S_READ: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		case (state_q)
			S_IDLE: req.ready = !out_valid_q || rsp.ready;
			default: req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Occupancy held across the ring read
	always_ff @(posedge clk) begin
		if (accept && ctl.rd_en) begin
			occ_s1 <= occ_next;
		end
	end

	// Response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_READ) begin
			out_valid_q <= 1'b1;
		end else if (accept && !ctl.rd_en) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response register payload
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			status_q <= STAT_DELIVERED;
			job_q    <= rd_data;
			occ_q    <= occ_s1;
		end else if (accept && !ctl.rd_en) begin
			status_q <= ctl.status;
			job_q    <= (ctl.status == STAT_INLINE) ? req.job_word : '0;
			occ_q    <= occ_next;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.job_out   = job_q;
	assign rsp.occupancy = occ_q;

`ifndef NO_ASSERTIONS
	// A ring read yields a response once the read cycle is over
	a_read_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.rd_en |=> ##1 (out_valid_q && status_q == STAT_DELIVERED))
		else $error("ring read did not produce a response");

	// A push on a full queue returns its own job to run inline
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.kind == KIND_PUSH && !ctl.wr_en
		|=> status_q == STAT_INLINE && job_q == $past(req.job_word))
		else $error("full push did not return its job");

	// Reported occupancy never exceeds the capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> occ_q <= OW'(DEPTH))
		else $error("occupancy above capacity");
`endif
endmodule
